FILE: rtl/core/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the environmental sensor compensation block.
// ----------------------------------------------------------------------------
package esc_pkg;

    // Measurement burst as it arrives from the sensor.
    typedef struct packed {
        logic [7:0] press_msb;
        logic [7:0] press_lsb;
        logic [7:0] press_xlsb;
        logic [7:0] temp_msb;
        logic [7:0] temp_lsb;
        logic [7:0] temp_xlsb;
        logic [7:0] hum_msb;
        logic [7:0] hum_lsb;
    } t_in_word;

    // Compensated result.
    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic [31:0]        press_q24_8;
        logic [16:0]        hum_q22_10;
        logic               press_div_zero;
    } t_out_word;

    // Assembled raw readings, as queued between front and back.
    typedef struct packed {
        logic [19:0] adc_p;
        logic [19:0] adc_t;
        logic [15:0] adc_h;
    } t_raw;

    // Calibration register file.
    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] press_lo;
        logic [63:0] press_hi;
        logic [15:0] press_nine;
        logic [63:0] hum;
    } t_coeffs;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HI   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_NINE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM        = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_DIV_ISSUE,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    // Sequencer steps, one shared multiply each.
    typedef logic [4:0] t_step;
    localparam t_step ST_V1  = 5'd0;
    localparam t_step ST_DD  = 5'd1;
    localparam t_step ST_TF  = 5'd2;
    localparam t_step ST_AA  = 5'd3;
    localparam t_step ST_C0  = 5'd4;
    localparam t_step ST_C1  = 5'd5;
    localparam t_step ST_E0  = 5'd6;
    localparam t_step ST_E1  = 5'd7;
    localparam t_step ST_E2  = 5'd8;
    localparam t_step ST_NUM = 5'd9;
    localparam t_step ST_PS  = 5'd10;
    localparam t_step ST_F   = 5'd11;
    localparam t_step ST_G   = 5'd12;
    localparam t_step ST_HA  = 5'd13;
    localparam t_step ST_H6  = 5'd14;
    localparam t_step ST_H3  = 5'd15;
    localparam t_step ST_HB0 = 5'd16;
    localparam t_step ST_HB1 = 5'd17;
    localparam t_step ST_V   = 5'd18;
    localparam t_step ST_W   = 5'd19;
    localparam t_step ST_H1  = 5'd20;

endpackage

FILE: rtl/core/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Accepts bursts, assembles the raw readings and queues them for the back.
// ----------------------------------------------------------------------------
module esc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  esc_pkg::t_in_word i_word,
    output logic             o_stall,
    output logic             o_avail,
    output esc_pkg::t_raw    o_raw,
    input  logic             i_pop
);
    import esc_pkg::*;

    t_raw       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_raw       w_raw;
    logic       w_push;

    assign w_raw.adc_p = {i_word.press_msb, i_word.press_lsb, i_word.press_xlsb[7:4]};
    assign w_raw.adc_t = {i_word.temp_msb, i_word.temp_lsb, i_word.temp_xlsb[7:4]};
    assign w_raw.adc_h = {i_word.hum_msb, i_word.hum_lsb};

    assign o_stall = (r_count == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign o_avail = (r_count != 2'd0);
    assign o_raw   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

endmodule

FILE: rtl/core/esc_mul.sv
// ----------------------------------------------------------------------------
// esc_mul
// 64x64 product, low 64 bits, from three 32x32 partial products.
// ----------------------------------------------------------------------------
module esc_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [1:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_pp;

    always_comb begin
        case (r_cnt)
            2'd0:    begin w_ma = r_a[31:0];  w_mb = r_b[31:0];  end
            2'd1:    begin w_ma = r_a[31:0];  w_mb = r_b[63:32]; end
            default: begin w_ma = r_a[63:32]; w_mb = r_b[31:0];  end
        endcase
    end

    assign w_pp   = {32'd0, w_ma} * {32'd0, w_mb};
    assign o_done = r_done;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy) begin
            if (r_cnt == 2'd0) begin
                r_acc <= w_pp;
            end else begin
                r_acc[63:32] <= r_acc[63:32] + w_pp[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/core/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// Signed 64-bit divide, truncating, restoring, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module esc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_fix;
    logic        r_done;
    logic [64:0] w_trial;

    assign w_trial = {r_rem, r_quo[63]} - {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_den <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_neg <= i_num[63] ^ i_den[63];
            r_rem <= 64'd0;
        end else if (r_busy) begin
            if (!w_trial[64]) begin
                r_rem <= w_trial[63:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= {r_rem[62:0], r_quo[63]};
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end else if (r_fix && r_neg) begin
            r_quo <= 64'd0 - r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            r_fix  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_done <= 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back
// Compensation sequencer around the shared multiply and divide units.
// ----------------------------------------------------------------------------
module esc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  esc_pkg::t_coeffs   i_coeffs,
    input  logic               i_avail,
    input  esc_pkg::t_raw      i_raw,
    output logic               o_pop,
    output logic               o_valid,
    output esc_pkg::t_out_word o_word,
    input  logic               i_stall
);
    import esc_pkg::*;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction

    t_state      r_state;
    t_state      n_state;
    t_step       r_step;
    t_step       w_step_nxt;
    t_raw        r_raw;
    logic [63:0] r_v1, r_dd, r_tf, r_aa, r_c, r_e, r_num, r_p, r_tmp, r_f;
    logic [31:0] r_temp, r_press, r_ha, r_t6, r_t3h, r_hb, r_v, r_w;
    logic [16:0] r_hum;
    logic        r_divz;
    t_out_word   r_out;
    logic        r_out_valid;

    logic        w_mul_start, w_mul_done, w_div_start, w_div_done, w_load_out, w_out_free;
    logic [63:0] w_ma, w_mb, w_prod, w_quo, w_a, w_ps, w_e_fin, w_psum;
    logic [31:0] w_m32, w_x, w_vs, w_hsum, w_vfin;
    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    assign t1 = {48'd0, i_coeffs.temp[15:0]};
    assign t2 = sx16(i_coeffs.temp[31:16]);
    assign t3 = sx16(i_coeffs.temp[47:32]);
    assign p1 = {48'd0, i_coeffs.press_lo[15:0]};
    assign p2 = sx16(i_coeffs.press_lo[31:16]);
    assign p3 = sx16(i_coeffs.press_lo[47:32]);
    assign p4 = sx16(i_coeffs.press_lo[63:48]);
    assign p5 = sx16(i_coeffs.press_hi[15:0]);
    assign p6 = sx16(i_coeffs.press_hi[31:16]);
    assign p7 = sx16(i_coeffs.press_hi[47:32]);
    assign p8 = sx16(i_coeffs.press_hi[63:48]);
    assign p9 = sx16(i_coeffs.press_nine);
    assign h1 = {24'd0, i_coeffs.hum[7:0]};
    assign h2 = {{16{i_coeffs.hum[23]}}, i_coeffs.hum[23:8]};
    assign h3 = {24'd0, i_coeffs.hum[31:24]};
    assign h4 = {{20{i_coeffs.hum[43]}}, i_coeffs.hum[43:32]};
    assign h5 = {{20{i_coeffs.hum[55]}}, i_coeffs.hum[55:44]};
    assign h6 = {{24{i_coeffs.hum[63]}}, i_coeffs.hum[63:56]};

    assign w_m32   = w_prod[31:0];
    assign w_a     = r_tf - 64'd128000;
    assign w_x     = r_tf[31:0] - 32'd76800;
    assign w_ps    = 64'($signed(r_p) >>> 13);
    assign w_vs    = 32'($signed(r_v) >>> 15);
    assign w_e_fin = 64'($signed(w_prod) >>> 33);
    assign w_psum  = r_p + r_f + 64'($signed(w_prod) >>> 19);
    assign w_hsum  = {2'd0, r_raw.adc_h, 14'd0} - {h4[11:0], 20'd0}
                     - w_m32 + 32'd16384;
    assign w_vfin  = r_v - 32'($signed(w_m32) >>> 4);

    // Skip the pressure steps when the divisor comes out zero
    assign w_step_nxt = (r_step == ST_E2 && w_e_fin == 64'd0) ? ST_HA : r_step + 5'd1;

    // Operand select for the shared multiply
    always_comb begin
        case (r_step)
            ST_V1:   begin w_ma = {47'd0, r_raw.adc_t[19:3]} - {t1[62:0], 1'b0}; w_mb = t2; end
            ST_DD:   begin
                w_ma = {48'd0, r_raw.adc_t[19:4]} - t1;
                w_mb = {48'd0, r_raw.adc_t[19:4]} - t1;
            end
            ST_TF:   begin w_ma = r_dd;  w_mb = t3; end
            ST_AA:   begin w_ma = w_a;   w_mb = w_a; end
            ST_C0:   begin w_ma = r_aa;  w_mb = p6; end
            ST_C1:   begin w_ma = w_a;   w_mb = p5; end
            ST_E0:   begin w_ma = r_aa;  w_mb = p3; end
            ST_E1:   begin w_ma = w_a;   w_mb = p2; end
            ST_E2:   begin w_ma = r_e;   w_mb = p1; end
            ST_NUM:  begin
                w_ma = 64'({(64'd1048576 - {44'd0, r_raw.adc_p}), 31'd0} - r_c);
                w_mb = 64'd3125;
            end
            ST_PS:   begin w_ma = p9;    w_mb = w_ps; end
            ST_F:    begin w_ma = r_tmp; w_mb = w_ps; end
            ST_G:    begin w_ma = p8;    w_mb = r_p; end
            ST_HA:   begin w_ma = {32'd0, h5};    w_mb = {32'd0, w_x}; end
            ST_H6:   begin w_ma = {32'd0, w_x};   w_mb = {32'd0, h6}; end
            ST_H3:   begin w_ma = {32'd0, w_x};   w_mb = {32'd0, h3}; end
            ST_HB0:  begin w_ma = {32'd0, r_t6};  w_mb = {32'd0, r_t3h}; end
            ST_HB1:  begin w_ma = {32'd0, r_hb};  w_mb = {32'd0, h2}; end
            ST_V:    begin w_ma = {32'd0, r_ha};  w_mb = {32'd0, r_hb}; end
            ST_W:    begin w_ma = {32'd0, w_vs};  w_mb = {32'd0, w_vs}; end
            ST_H1:   begin w_ma = {32'd0, r_w};   w_mb = {32'd0, h1}; end
            default: begin w_ma = 64'd0; w_mb = 64'd0; end
        endcase
    end

    esc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_e),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_out_free = !r_out_valid || !i_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_avail) n_state = S_ISSUE;
            S_ISSUE:     n_state = S_WAIT;
            S_WAIT:      begin
                if (w_mul_done) begin
                    if (r_step == ST_NUM) begin
                        n_state = S_DIV_ISSUE;
                    end else if (r_step == ST_H1) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ISSUE;
                    end
                end
            end
            S_DIV_ISSUE: n_state = S_DIV_WAIT;
            S_DIV_WAIT:  if (w_div_done) n_state = S_ISSUE;
            S_DONE:      if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_pop       = (r_state == S_IDLE) && i_avail;
        w_mul_start = (r_state == S_ISSUE);
        w_div_start = (r_state == S_DIV_ISSUE);
        w_load_out  = (r_state == S_DONE) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_raw   <= i_raw;
            r_step  <= ST_V1;
            r_divz  <= 1'b0;
            r_press <= 32'd0;
        end else if (r_state == S_WAIT && w_mul_done) begin
            r_step <= w_step_nxt;
            case (r_step)
                ST_V1:  r_v1 <= 64'($signed(w_prod) >>> 11);
                ST_DD:  r_dd <= 64'($signed(w_prod) >>> 12);
                ST_TF:  r_tf <= r_v1 + 64'($signed(w_prod) >>> 14);
                ST_AA:  begin
                    r_aa   <= w_prod;
                    r_temp <= 32'($signed({r_tf[61:0], 2'd0} + r_tf + 64'd128) >>> 8);
                end
                ST_C0:  r_c <= w_prod;
                ST_C1:  r_c <= r_c + {w_prod[46:0], 17'd0} + {p4[28:0], 35'd0};
                ST_E0:  r_e <= 64'($signed(w_prod) >>> 8);
                ST_E1:  r_e <= r_e + {w_prod[51:0], 12'd0} + (64'd1 << 47);
                ST_E2:  begin
                    r_e <= w_e_fin;
                    if (w_e_fin == 64'd0) begin
                        r_divz <= 1'b1;
                    end
                end
                ST_NUM: r_num <= w_prod;
                ST_PS:  r_tmp <= w_prod;
                ST_F:   r_f   <= 64'($signed(w_prod) >>> 25);
                ST_G:   r_press <= w_psum[39:8] + {p7[27:0], 4'd0};
                ST_HA:  r_ha  <= 32'($signed(w_hsum) >>> 15);
                ST_H6:  r_t6  <= 32'($signed(w_m32) >>> 10);
                ST_H3:  r_t3h <= 32'($signed(w_m32) >>> 11) + 32'd32768;
                ST_HB0: r_hb  <= 32'($signed(w_m32) >>> 10) + 32'd2097152;
                ST_HB1: r_hb  <= 32'($signed(w_m32 + 32'd8192) >>> 14);
                ST_V:   r_v   <= w_m32;
                ST_W:   r_w   <= 32'($signed(w_m32) >>> 7);
                ST_H1:  begin
                    if (w_vfin[31]) begin
                        r_hum <= 17'd0;
                    end else if (w_vfin > 32'd419430400) begin
                        r_hum <= 17'd102400;
                    end else begin
                        r_hum <= w_vfin[28:12];
                    end
                end
                default: ;
            endcase
        end else if (r_state == S_DIV_WAIT && w_div_done) begin
            r_p    <= w_quo;
            r_step <= ST_PS;
        end
        if (w_load_out) begin
            r_out.temp_centi     <= r_temp;
            r_out.press_q24_8    <= r_press;
            r_out.hum_q22_10     <= r_hum;
            r_out.press_div_zero <= r_divz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

`ifndef NO_ASSERTIONS
    a_mul_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_WAIT))
        else $error("multiply finished outside its wait state");
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV_WAIT))
        else $error("divide finished outside its wait state");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> r_out_valid)
        else $error("result load did not raise valid");
    a_no_div_by_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (r_e != 64'd0))
        else $error("divide started with zero divisor");
`endif

endmodule

FILE: rtl/core/env_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation_top
// Integer compensation of one pressure/temperature/humidity burst per word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  input   | in        | i_valid / o_stall     | i_word  (t_in_word)
//  output  | out       | o_valid / i_stall     | o_word  (t_out_word)
//  config  | in        | i_cfg_we              | i_cfg_index, i_cfg_data
//
//  With the output free, the back pops a word, runs 21 multiplies on the
//  one shared 32x32 multiplier (issue, three partial products, finish),
//  with a bit-serial divide after the tenth, and loads the result. A zero
//  pressure divisor skips the divide and four multiplies. A stalled output
//  holds the back in its last state.
//  Reset is synchronous, active low; it clears the calibration registers.
//  The front queues two words, so input is taken while the back is busy and
//  while a finished result waits on a stalled output.
// ----------------------------------------------------------------------------
module env_sensor_compensation_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  esc_pkg::t_in_word                   i_word,
    output logic                                o_stall,
    output logic                                o_valid,
    output esc_pkg::t_out_word                  o_word,
    input  logic                                i_stall,
    input  logic                                i_cfg_we,
    input  logic [esc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import esc_pkg::*;

    t_coeffs r_coeffs;
    logic    w_avail;
    logic    w_pop;
    t_raw    w_raw;

    // Calibration write decode; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TEMP:       r_coeffs.temp       <= i_cfg_data[47:0];
                REG_PRESS_LO:   r_coeffs.press_lo   <= i_cfg_data;
                REG_PRESS_HI:   r_coeffs.press_hi   <= i_cfg_data;
                REG_PRESS_NINE: r_coeffs.press_nine <= i_cfg_data[15:0];
                REG_HUM:        r_coeffs.hum        <= i_cfg_data;
                default:        r_coeffs <= r_coeffs;
            endcase
        end
    end

    // Front: assemble raw readings and hold them in the queue
    esc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_word  (i_word),
        .o_stall (o_stall),
        .o_avail (w_avail),
        .o_raw   (w_raw),
        .i_pop   (w_pop)
    );

    // Back: sequence the compensation and register the result
    esc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coeffs (r_coeffs),
        .i_avail  (w_avail),
        .i_raw    (w_raw),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .o_word   (o_word),
        .i_stall  (i_stall)
    );

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for env_sensor_compensation_top. A built-in model of the
// integer compensation predicts every untyped result word; directed bursts come from
// a table, then random bursts run under several calibration sets, with
// random idling on both channels, a long output hold and a full drain.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import esc_pkg::*;

    // Index beyond the register file; the block must ignore it.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd5;
    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE       = 200;
    localparam int WATCHDOG_MAX = 5000;
    localparam int PHASE_WORDS  = 160;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    t_in_word              i_word;
    logic                  o_stall;
    logic                  o_valid;
    t_out_word             o_word;
    logic                  i_stall;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    env_sensor_compensation_top uut (.*);

    // Local copy of the calibration registers.
    logic [47:0] cal_temp;
    logic [63:0] cal_press_lo;
    logic [63:0] cal_press_hi;
    logic [15:0] cal_press_nine;
    logic [63:0] cal_hum;

    t_out_word pending_q[$];
    int        fail_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_request;

    // Directed bursts; typed rows carry a result that needs no arithmetic.
    typedef struct {
        t_in_word  burst;
        bit        typed;
        t_out_word result;
    } t_row;

    // With every coefficient at zero: fine temperature 0, divisor 0,
    // humidity 0, so only the divide-by-zero flag is set.
    localparam t_out_word ZERO_CAL = '{temp_centi: 0, press_q24_8: 0,
                                       hum_q22_10: 0, press_div_zero: 1'b1};

    t_row reset_rows[5] = '{
        '{64'h0000_0000_0000_0000, 1'b1, ZERO_CAL},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ZERO_CAL},
        '{64'hAA55_AA55_AA55_AA55, 1'b1, ZERO_CAL},
        '{64'h55AA_55AA_55AA_55AA, 1'b1, ZERO_CAL},
        '{64'h6556_C07E_ED00_6650, 1'b1, ZERO_CAL}
    };

    t_row typical_rows[14] = '{
        '{64'h0000_0000_0000_0000, 1'b0, '0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{64'h655A_C07E_ED00_6650, 1'b0, '0},
        '{64'h655A_CF7E_ED0F_6650, 1'b0, '0},  // low nibbles must be ignored
        '{64'h8000_0080_0000_8000, 1'b0, '0},
        '{64'h7FFF_F07F_FFF0_7FFF, 1'b0, '0},
        '{64'h655A_C06B_6F00_FFFF, 1'b0, '0},  // humidity raw at max: clamp high
        '{64'h655A_C07E_ED00_0000, 1'b0, '0},  // humidity raw zero: clamp low
        '{64'h0000_0000_0000_6650, 1'b0, '0},
        '{64'hFFFF_F000_0000_6650, 1'b0, '0},
        '{64'h6556_C0FF_FFF0_6650, 1'b0, '0},  // hot extreme
        '{64'h6556_C000_0000_6650, 1'b0, '0},  // cold extreme
        '{64'h1234_5678_9ABC_DEF0, 1'b0, '0},
        '{64'hEDCB_A987_6543_210F, 1'b0, '0}
    };

    // Integer compensation of one burst against the local calibration copy.
    function automatic t_out_word compensate(t_in_word w);
        logic signed [63:0] adc_p, adc_t, t1, t2, t3, v1, d, v2, fine, tc;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] a, c, e, num, q, ps, f, g, pr;
        logic signed [31:0] adc_h, h1, h2, h3, h4, h5, h6, x, ha, hb, v, vs;
        t_out_word r;
        adc_p = signed'({44'd0, w.press_msb, w.press_lsb, w.press_xlsb[7:4]});
        adc_t = signed'({44'd0, w.temp_msb, w.temp_lsb, w.temp_xlsb[7:4]});
        adc_h = signed'({16'd0, w.hum_msb, w.hum_lsb});

        t1 = signed'({48'd0, cal_temp[15:0]});
        t2 = 64'(signed'(cal_temp[31:16]));
        t3 = 64'(signed'(cal_temp[47:32]));
        v1   = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
        d    = (adc_t >>> 4) - t1;
        v2   = (((d * d) >>> 12) * t3) >>> 14;
        fine = v1 + v2;
        tc   = (fine * 5 + 128) >>> 8;
        r.temp_centi = tc[31:0];

        p1 = signed'({48'd0, cal_press_lo[15:0]});
        p2 = 64'(signed'(cal_press_lo[31:16]));
        p3 = 64'(signed'(cal_press_lo[47:32]));
        p4 = 64'(signed'(cal_press_lo[63:48]));
        p5 = 64'(signed'(cal_press_hi[15:0]));
        p6 = 64'(signed'(cal_press_hi[31:16]));
        p7 = 64'(signed'(cal_press_hi[47:32]));
        p8 = 64'(signed'(cal_press_hi[63:48]));
        p9 = 64'(signed'(cal_press_nine));
        a = fine - 128000;
        c = a * a * p6 + ((a * p5) <<< 17) + (p4 <<< 35);
        e = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
        e = (((64'sd1 <<< 47) + e) * p1) >>> 33;
        if (e == 0) begin
            r.press_q24_8    = '0;
            r.press_div_zero = 1'b1;
        end else begin
            num = (((64'sd1048576 - adc_p) <<< 31) - c) * 3125;
            // most negative over minus one wraps to itself
            if (num == 64'sh8000_0000_0000_0000 && e == -64'sd1)
                q = num;
            else
                q = num / e;
            ps = q >>> 13;
            f  = (p9 * ps * ps) >>> 25;
            g  = (p8 * q) >>> 19;
            pr = ((q + f + g) >>> 8) + (p7 <<< 4);
            r.press_q24_8    = pr[31:0];
            r.press_div_zero = 1'b0;
        end

        h1 = signed'({24'd0, cal_hum[7:0]});
        h2 = 32'(signed'(cal_hum[23:8]));
        h3 = signed'({24'd0, cal_hum[31:24]});
        h4 = 32'(signed'(cal_hum[43:32]));
        h5 = 32'(signed'(cal_hum[55:44]));
        h6 = 32'(signed'(cal_hum[63:56]));
        x  = signed'(fine[31:0]) - 32'sd76800;
        ha = ((adc_h <<< 14) - (h4 <<< 20) - h5 * x + 32'sd16384) >>> 15;
        hb = ((x * h6) >>> 10) * (((x * h3) >>> 11) + 32'sd32768);
        hb = (hb >>> 10) + 32'sd2097152;
        hb = ((hb * h2) + 32'sd8192) >>> 14;
        v  = ha * hb;
        vs = v >>> 15;
        v  = v - ((((vs * vs) >>> 7) * h1) >>> 4);
        if (v < 0)
            v = 0;
        else if (v > 32'sd419430400)
            v = 32'sd419430400;
        r.hum_q22_10 = v[28:12];
        return r;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side: random stall, or one long hold when asked.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Check each delivered word against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result word %h", o_word);
                fail_count++;
            end else begin
                want = pending_q.pop_front();
                if (o_word.temp_centi !== want.temp_centi) begin
                    $error("temp_centi: expected %0d, got %0d",
                           want.temp_centi, o_word.temp_centi);
                    fail_count++;
                end
                if (o_word.press_q24_8 !== want.press_q24_8) begin
                    $error("press_q24_8: expected %h, got %h",
                           want.press_q24_8, o_word.press_q24_8);
                    fail_count++;
                end
                if (o_word.hum_q22_10 !== want.hum_q22_10) begin
                    $error("hum_q22_10: expected %0d, got %0d",
                           want.hum_q22_10, o_word.hum_q22_10);
                    fail_count++;
                end
                if (o_word.press_div_zero !== want.press_div_zero) begin
                    $error("press_div_zero: expected %b, got %b",
                           want.press_div_zero, o_word.press_div_zero);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: abort when no word moves on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_MAX) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offer one burst, hold it until taken, and record its prediction.
    // Valid is left high so a following burst can go straight out.
    task automatic send_burst(input t_in_word w, input bit typed, input t_out_word result);
        int gap;
        gap = (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) ?
              $urandom_range(1, 6) : 0;
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_stall);
        pending_q.push_back(typed ? result : compensate(w));
    endtask

    // Drop valid and wait for every outstanding result, then let the
    // back end settle so a register write cannot land mid-calculation.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write one register; enable stays high for back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_TEMP:       cal_temp       = data[47:0];
            REG_PRESS_LO:   cal_press_lo   = data;
            REG_PRESS_HI:   cal_press_hi   = data;
            REG_PRESS_NINE: cal_press_nine = data[15:0];
            REG_HUM:        cal_hum        = data;
            default: ;
        endcase
    endtask

    task automatic load_cal(input logic [63:0] t, pl, ph, p9, h);
        write_reg(REG_TEMP, t);
        write_reg(REG_PRESS_LO, pl);
        write_reg(REG_PRESS_HI, ph);
        write_reg(REG_PRESS_NINE, p9);
        write_reg(REG_HUM, h);
        write_reg(REG_UNMAPPED, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly plausible readings, the rest raw noise over every bit.
    function automatic t_in_word rand_burst();
        t_in_word w;
        w = rand64();
        if ($urandom_range(3) != 0) begin
            w.press_msb = 8'($urandom_range(8'h40, 8'h70));
            w.temp_msb  = 8'($urandom_range(8'h70, 8'h90));
            w.hum_msb   = 8'($urandom_range(8'h40, 8'h80));
        end
        return w;
    endfunction

    task automatic run_random(input int words, input bit mid_pause);
        for (int k = 0; k < words; k++) begin
            if (mid_pause && k == words / 2)
                drain();
            send_burst(rand_burst(), 1'b0, '0);
        end
        drain();
    endtask

    // Typical factory calibration, packed as the registers expect.
    localparam logic [63:0] TYP_TEMP = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PLO  = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] TYP_PHI  = {16'hC708, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [63:0] TYP_P9   = 64'd6000;
    localparam logic [63:0] TYP_HUM  = {8'd30, 12'd0, 12'd324, 8'd0, 16'd362, 8'd75};

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_word      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        fail_count  = 0;
        hold_request = 1'b0;
        cal_temp = '0; cal_press_lo = '0; cal_press_hi = '0;
        cal_press_nine = '0; cal_hum = '0;
        send_idle_pct = 30;
        recv_idle_pct = 62;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: every result is known without arithmetic.
        foreach (reset_rows[n])
            send_burst(reset_rows[n].burst, 1'b1, reset_rows[n].result);
        drain();

        load_cal(TYP_TEMP, TYP_PLO, TYP_PHI, TYP_P9, TYP_HUM);
        foreach (typical_rows[n])
            send_burst(typical_rows[n].burst, 1'b0, '0);
        drain();

        // Long output hold while bursts keep coming: fills the front queue.
        hold_request = 1'b1;
        run_random(PHASE_WORDS, 1'b0);

        load_cal(rand64(), rand64(), rand64(), rand64(), rand64());
        run_random(PHASE_WORDS, 1'b0);

        send_idle_pct = 62;
        recv_idle_pct = 30;
        load_cal('1, '1, '1, '1, '1);
        run_random(PHASE_WORDS, 1'b0);

        // Sender pauses halfway until everything has come back.
        load_cal(rand64(), rand64(), rand64(), rand64(), rand64());
        run_random(PHASE_WORDS, 1'b1);

        // P1 zero forces the zero divisor path.
        load_cal(rand64(), rand64() & ~64'hFFFF, rand64(), rand64(), rand64());
        run_random(PHASE_WORDS / 2, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_cal(rand64(), rand64(), rand64(), rand64(), rand64());
        run_random(PHASE_WORDS, 1'b0);

        load_cal(TYP_TEMP, TYP_PLO, TYP_PHI, TYP_P9, TYP_HUM);
        run_random(PHASE_WORDS, 1'b0);

        // Most negative signed coefficients, unsigned ones at max.
        load_cal({16'd0, 16'h8000, 16'h8000, 16'hFFFF},
                 {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                 {4{16'h8000}}, 64'h8000, {8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF});
        run_random(PHASE_WORDS, 1'b0);

        load_cal(TYP_TEMP, TYP_PLO, TYP_PHI, TYP_P9, TYP_HUM);
        run_random(PHASE_WORDS / 2, 1'b0);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
